>>> rtl/core/rgba_palette_dither_mapper_defines.svh
// Assertion macros for the top-level file, which checks its own logic with them.
`ifndef RGBA_PALETTE_DITHER_MAPPER_DEFINES_SVH
`define RGBA_PALETTE_DITHER_MAPPER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPDM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPDM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rpdm_pkg.sv
package rpdm_pkg;

    localparam int CHANNELS  = 4;
    localparam int BYTE_BITS = 8;
    localparam int DIST_BITS = 18;
    localparam int ERR_SHIFT = 10;
    localparam int ERR_ROUND = 1023;

    localparam int SHARE_CUR_AHEAD   = 448;
    localparam int SHARE_NEXT_BEHIND = 192;
    localparam int SHARE_NEXT_BELOW  = 320;
    localparam int SHARE_NEXT_AHEAD  = 64;

    localparam logic [1:0] CFG_ROW_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_MAX_LEVEL     = 2'd1;
    localparam logic [1:0] CFG_PALETTE_COUNT = 2'd2;

    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_PIXEL   = 1'b1;

    typedef logic [CHANNELS-1:0][BYTE_BITS-1:0] pixel_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] code;
        pixel_t               color;
    } entry_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_ADJ  = 6'b000100,
        ST_SRCH = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // Weight of the next-row neighbour at offset slot from the left-hand cell.
    function automatic logic [8:0] next_weight(input logic fwd, input logic [1:0] slot);
        logic [8:0] w;
        case (slot)
            2'd0:    w = fwd ? 9'(SHARE_NEXT_BEHIND) : 9'(SHARE_NEXT_AHEAD);
            2'd1:    w = 9'(SHARE_NEXT_BELOW);
            2'd2:    w = fwd ? 9'(SHARE_NEXT_AHEAD) : 9'(SHARE_NEXT_BEHIND);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/rpdm_err_bank.sv
module rpdm_err_bank #(
    parameter int DEPTH     = 1026,
    parameter int DATA_BITS = 96
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clr_start,
    output logic                         busy,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_BITS-1:0]         rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [DATA_BITS-1:0]         wr_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int TW = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] err_ram_reg [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;
    logic                 clr_active_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic [TW-1:0]        top_reg;

    assign busy    = clr_active_reg;
    assign rd_data = rd_data_reg;

    // The top mark bounds the entries written since the last clear, so a
    // clear only sweeps those.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            top_reg        <= TW'(DEPTH);
        end else if (clr_active_reg) begin
            if (TW'(clr_addr_reg) + TW'(1) == top_reg) begin
                clr_active_reg <= 1'b0;
                clr_addr_reg   <= '0;
                top_reg        <= '0;
            end else begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end else if (clr_start) begin
            clr_active_reg <= (top_reg != '0);
            clr_addr_reg   <= '0;
        end else if (wr_en && TW'(wr_addr) >= top_reg) begin
            top_reg <= TW'(wr_addr) + TW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            err_ram_reg[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            err_ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= err_ram_reg[rd_addr];
        end
    end

endmodule

>>> rtl/core/rpdm_nearest.sv
module rpdm_nearest #(
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  rpdm_pkg::entry_t         wr_entry,
    input  logic                     start,
    input  logic [$clog2(DEPTH)-1:0] last_index,
    input  rpdm_pkg::pixel_t         adj,
    output logic                     done,
    output rpdm_pkg::entry_t         best
);

    localparam int PW = $clog2(DEPTH);

    rpdm_pkg::entry_t              pal_ram_reg [DEPTH];
    rpdm_pkg::entry_t              rd_entry_reg;
    rpdm_pkg::entry_t              best_reg;
    logic [PW-1:0]                 addr_reg;
    logic                          issuing_reg;
    logic                          cmp_valid_reg;
    logic                          cmp_last_reg;
    logic                          first_reg;
    logic                          done_reg;
    logic [rpdm_pkg::DIST_BITS-1:0] best_dist_reg;
    logic [rpdm_pkg::DIST_BITS-1:0] cand_dist;
    logic                          win;

    assign done = done_reg;
    assign best = best_reg;

    always_comb begin
        logic signed [8:0]  diff;
        logic signed [17:0] sq;
        cand_dist = '0;
        for (int c = 0; c < rpdm_pkg::CHANNELS; c++) begin
            diff      = $signed({1'b0, adj[c]}) - $signed({1'b0, rd_entry_reg.color[c]});
            sq        = 18'(diff) * 18'(diff);
            cand_dist = cand_dist + rpdm_pkg::DIST_BITS'(unsigned'(sq));
        end
        win = first_reg || (cand_dist < best_dist_reg);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pal_ram_reg[wr_addr] <= wr_entry;
        end
        if (issuing_reg) begin
            rd_entry_reg <= pal_ram_reg[addr_reg];
        end
        if (cmp_valid_reg && win) begin
            best_dist_reg <= cand_dist;
            best_reg      <= rd_entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= '0;
            issuing_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            first_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            cmp_valid_reg <= issuing_reg;
            cmp_last_reg  <= issuing_reg && (addr_reg == last_index);
            done_reg      <= cmp_valid_reg && cmp_last_reg;
            if (start) begin
                addr_reg    <= '0;
                issuing_reg <= 1'b1;
                first_reg   <= 1'b1;
            end else begin
                if (issuing_reg) begin
                    if (addr_reg == last_index) begin
                        issuing_reg <= 1'b0;
                    end else begin
                        addr_reg <= addr_reg + PW'(1);
                    end
                end
                if (cmp_valid_reg) begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

endmodule

>>> rtl/core/rgba_palette_dither_mapper.sv
// A pixel's result is presented once the search, which reads one palette entry a cycle from
// memory, has finished; no further request is taken until that result has been presented.
// The last pixel of a row is followed by a sweep that zeroes the old error row, one entry a
// cycle over the entries touched (at most MAX_ROW_WIDTH + 2); a start of image sweeps both.
// Reset is synchronous and is followed by a sweep of all MAX_ROW_WIDTH + 2 entries of both rows.
`include "rgba_palette_dither_mapper_defines.svh"

module rgba_palette_dither_mapper #(
    parameter int MAX_ROW_WIDTH = 1024,
    parameter int PALETTE_DEPTH = 256,
    parameter int ERROR_BITS    = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic        s_start_of_image,
    input  logic [7:0]  s_entry_index,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_alpha,
    input  logic [7:0]  s_out_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_code,
    output logic        m_row_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int ROW_DEPTH = MAX_ROW_WIDTH + 2;
    localparam int AW        = $clog2(ROW_DEPTH);
    localparam int CW        = $clog2(MAX_ROW_WIDTH + 1);
    localparam int PW        = $clog2(PALETTE_DEPTH);
    localparam int EB        = ERROR_BITS;
    localparam int EBX       = ERROR_BITS + 1;
    localparam int EW        = rpdm_pkg::CHANNELS * EB;
    localparam logic signed [EB:0] ERR_HI = {2'b00, {(EB - 1){1'b1}}};
    localparam logic signed [EB:0] ERR_LO = {2'b11, {(EB - 1){1'b0}}};

    rpdm_pkg::state_t state_reg, state_next;
    logic [1:0]       step_reg;
    logic             sel_reg;
    logic             reverse_reg;
    logic [CW-1:0]    column_reg;
    logic [CW-1:0]    col_reg;
    logic             last_reg;
    rpdm_pkg::pixel_t pix_reg;
    rpdm_pkg::pixel_t adj_reg;
    logic signed [8:0] diff_reg [rpdm_pkg::CHANNELS];
    logic [10:0]      row_width_reg;
    logic [7:0]       max_level_reg;
    logic [8:0]       palette_count_reg;
    logic             m_valid_reg;
    logic [7:0]       m_code_reg;
    logic             m_row_end_reg;

    logic          accept, pixel_acc, pal_wr, clear_img, fin_fire, any_busy, fwd;
    logic [CW-1:0] width_eff, pos, col;
    logic          last;
    logic [PW-1:0] last_index;
    rpdm_pkg::pixel_t adj;
    rpdm_pkg::entry_t best;
    logic          search_done;

    logic          bk_clr [2];
    logic          bk_busy [2];
    logic          bk_rd_en [2];
    logic          bk_wr_en [2];
    logic [AW-1:0] bk_rd_addr [2];
    logic [AW-1:0] bk_wr_addr [2];
    logic [EW-1:0] bk_rd_data [2];
    logic [EW-1:0] bk_wr_data [2];

    logic          cur_rd_en, cur_wr_en, nxt_rd_en, nxt_wr_en;
    logic [AW-1:0] cur_rd_addr, cur_wr_addr, nxt_rd_addr, nxt_wr_addr;
    logic [EW-1:0] cur_rd_data, nxt_rd_data, cur_wr_data, nxt_wr_data;

    assign any_busy  = bk_busy[0] || bk_busy[1];
    assign s_ready   = (state_reg == rpdm_pkg::ST_IDLE) && !any_busy;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign pixel_acc = accept && (s_mode == rpdm_pkg::MODE_PIXEL);
    assign pal_wr    = accept && (s_mode == rpdm_pkg::MODE_PALETTE)
                       && (32'(s_entry_index) < PALETTE_DEPTH);
    assign clear_img = pixel_acc && s_start_of_image;
    assign fin_fire  = (state_reg == rpdm_pkg::ST_FIN) && (!m_valid_reg || m_ready);
    assign fwd       = !reverse_reg;

    assign m_valid   = m_valid_reg;
    assign m_code    = m_code_reg;
    assign m_row_end = m_row_end_reg;

    always_comb begin
        int rw, pc;
        rw = 32'(row_width_reg);
        if (rw == 0) begin
            rw = 1;
        end else if (rw > MAX_ROW_WIDTH) begin
            rw = MAX_ROW_WIDTH;
        end
        width_eff = CW'(rw);
        pc = 32'(palette_count_reg);
        if (pc == 0) begin
            pc = 1;
        end else if (pc > PALETTE_DEPTH) begin
            pc = PALETTE_DEPTH;
        end
        last_index = PW'(pc - 1);
        pos  = (column_reg >= width_eff) ? width_eff - CW'(1) : column_reg;
        last = (pos == width_eff - CW'(1));
        col  = reverse_reg ? width_eff - CW'(1) - pos : pos;
    end

    always_comb begin
        logic signed [EB-1:0] e;
        logic signed [EB-1:0] t;
        logic signed [EB:0]   q;
        logic signed [EB:0]   v;
        logic signed [EB:0]   lim;
        lim = $signed({{(EB - 7){1'b0}}, max_level_reg});
        for (int c = 0; c < rpdm_pkg::CHANNELS; c++) begin
            e = $signed(cur_rd_data[c*EB +: EB]);
            t = e + (e[EB-1] ? EB'(rpdm_pkg::ERR_ROUND) : EB'(0));
            q = EBX'(t) >>> rpdm_pkg::ERR_SHIFT;
            v = q + $signed({{(EB - 7){1'b0}}, pix_reg[c]});
            if (v < 0) begin
                adj[c] = '0;
            end else if (v > lim) begin
                adj[c] = max_level_reg;
            end else begin
                adj[c] = v[7:0];
            end
        end
    end

    // Each write falls in the cycle after its read; the three next-row cells are distinct,
    // so a write never meets a read of the same entry.
    always_comb begin
        logic [1:0]         wslot;
        logic signed [19:0] prod;
        logic signed [EB:0] old_v, shr, sum;
        wslot       = step_reg - 2'd1;
        cur_rd_en   = ((state_reg == rpdm_pkg::ST_PREP) && !any_busy)
                      || ((state_reg == rpdm_pkg::ST_UPD) && (step_reg == 2'd0));
        cur_rd_addr = (state_reg == rpdm_pkg::ST_PREP) ? AW'(col) + AW'(1)
                      : (fwd ? AW'(col_reg) + AW'(2) : AW'(col_reg));
        cur_wr_en   = (state_reg == rpdm_pkg::ST_UPD) && (step_reg == 2'd1);
        cur_wr_addr = fwd ? AW'(col_reg) + AW'(2) : AW'(col_reg);
        nxt_rd_en   = (state_reg == rpdm_pkg::ST_UPD) && (step_reg != 2'd3);
        nxt_rd_addr = AW'(col_reg) + AW'(step_reg);
        nxt_wr_en   = (state_reg == rpdm_pkg::ST_UPD) && (step_reg != 2'd0);
        nxt_wr_addr = AW'(col_reg) + AW'(wslot);
        for (int c = 0; c < rpdm_pkg::CHANNELS; c++) begin
            prod  = 20'(diff_reg[c])
                    * 20'($signed({1'b0, 9'(rpdm_pkg::SHARE_CUR_AHEAD)}));
            old_v = EBX'($signed(cur_rd_data[c*EB +: EB]));
            shr   = EBX'(prod);
            sum   = old_v + shr;
            cur_wr_data[c*EB +: EB] = (sum > ERR_HI) ? ERR_HI[EB-1:0]
                                      : (sum < ERR_LO) ? ERR_LO[EB-1:0] : sum[EB-1:0];
            prod  = 20'(diff_reg[c])
                    * 20'($signed({1'b0, rpdm_pkg::next_weight(fwd, wslot)}));
            old_v = EBX'($signed(nxt_rd_data[c*EB +: EB]));
            shr   = EBX'(prod);
            sum   = old_v + shr;
            nxt_wr_data[c*EB +: EB] = (sum > ERR_HI) ? ERR_HI[EB-1:0]
                                      : (sum < ERR_LO) ? ERR_LO[EB-1:0] : sum[EB-1:0];
        end
    end

    assign cur_rd_data = bk_rd_data[sel_reg];
    assign nxt_rd_data = bk_rd_data[~sel_reg];

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            if (1'(b) == sel_reg) begin
                bk_rd_en[b]   = cur_rd_en;
                bk_rd_addr[b] = cur_rd_addr;
                bk_wr_en[b]   = cur_wr_en;
                bk_wr_addr[b] = cur_wr_addr;
                bk_wr_data[b] = cur_wr_data;
            end else begin
                bk_rd_en[b]   = nxt_rd_en;
                bk_rd_addr[b] = nxt_rd_addr;
                bk_wr_en[b]   = nxt_wr_en;
                bk_wr_addr[b] = nxt_wr_addr;
                bk_wr_data[b] = nxt_wr_data;
            end
            bk_clr[b] = clear_img || (fin_fire && last_reg && (1'(b) == sel_reg));
        end
    end

    for (genvar b = 0; b < 2; b++) begin : g_bank
        rpdm_err_bank #(
            .DEPTH     (ROW_DEPTH),
            .DATA_BITS (EW)
        ) u_bank (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clr_start (bk_clr[b]),
            .busy      (bk_busy[b]),
            .rd_en     (bk_rd_en[b]),
            .rd_addr   (bk_rd_addr[b]),
            .rd_data   (bk_rd_data[b]),
            .wr_en     (bk_wr_en[b]),
            .wr_addr   (bk_wr_addr[b]),
            .wr_data   (bk_wr_data[b])
        );
    end

    rpdm_nearest #(
        .DEPTH (PALETTE_DEPTH)
    ) u_nearest (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (pal_wr),
        .wr_addr    (PW'(s_entry_index)),
        .wr_entry   ({s_out_code, s_alpha, s_blue, s_green, s_red}),
        .start      (state_reg == rpdm_pkg::ST_ADJ),
        .last_index (last_index),
        .adj        (adj_reg),
        .done       (search_done),
        .best       (best)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rpdm_pkg::ST_IDLE: if (pixel_acc) state_next = rpdm_pkg::ST_PREP;
            rpdm_pkg::ST_PREP: if (!any_busy) state_next = rpdm_pkg::ST_ADJ;
            rpdm_pkg::ST_ADJ:  state_next = rpdm_pkg::ST_SRCH;
            rpdm_pkg::ST_SRCH: if (search_done) state_next = rpdm_pkg::ST_UPD;
            rpdm_pkg::ST_UPD:  if (step_reg == 2'd3) state_next = rpdm_pkg::ST_FIN;
            rpdm_pkg::ST_FIN:  if (fin_fire) state_next = rpdm_pkg::ST_IDLE;
            default:           state_next = rpdm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= rpdm_pkg::ST_IDLE;
            step_reg          <= '0;
            sel_reg           <= 1'b0;
            reverse_reg       <= 1'b0;
            column_reg        <= '0;
            m_valid_reg       <= 1'b0;
            row_width_reg     <= 11'd1024;
            max_level_reg     <= 8'd255;
            palette_count_reg <= 9'd256;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rpdm_pkg::CFG_ROW_WIDTH:     row_width_reg     <= cfg_data;
                    rpdm_pkg::CFG_MAX_LEVEL:     max_level_reg     <= cfg_data[7:0];
                    rpdm_pkg::CFG_PALETTE_COUNT: palette_count_reg <= cfg_data[8:0];
                    default: ;
                endcase
            end
            if (clear_img) begin
                column_reg  <= '0;
                reverse_reg <= 1'b0;
            end
            if (state_reg == rpdm_pkg::ST_SRCH) begin
                step_reg <= '0;
            end else if (state_reg == rpdm_pkg::ST_UPD) begin
                step_reg <= step_reg + 2'd1;
            end
            if (fin_fire) begin
                m_valid_reg <= 1'b1;
                if (last_reg) begin
                    column_reg  <= '0;
                    reverse_reg <= ~reverse_reg;
                    sel_reg     <= ~sel_reg;
                end else begin
                    column_reg <= pos + CW'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pixel_acc) begin
            pix_reg <= {s_alpha, s_blue, s_green, s_red};
        end
        if ((state_reg == rpdm_pkg::ST_PREP) && !any_busy) begin
            col_reg  <= col;
            last_reg <= last;
        end
        if (state_reg == rpdm_pkg::ST_ADJ) begin
            adj_reg <= adj;
        end
        if ((state_reg == rpdm_pkg::ST_SRCH) && search_done) begin
            for (int c = 0; c < rpdm_pkg::CHANNELS; c++) begin
                diff_reg[c] <= $signed({1'b0, adj_reg[c]}) - $signed({1'b0, best.color[c]});
            end
        end
        if (fin_fire) begin
            m_code_reg    <= best.code;
            m_row_end_reg <= last_reg;
        end
    end

    `RPDM_ASSERT_SAME(a_done_in_search, aclk, aresetn, search_done,
        state_reg == rpdm_pkg::ST_SRCH, "search finished outside the search state")
    `RPDM_ASSERT_SAME(a_no_clear_in_update, aclk, aresetn, state_reg == rpdm_pkg::ST_UPD,
        !bk_busy[0] && !bk_busy[1], "error row cleared during an update")
    `RPDM_ASSERT_NEXT(a_row_end_swaps, aclk, aresetn, fin_fire && last_reg,
        sel_reg != $past(sel_reg), "error rows not swapped at row end")

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int ROW_CELLS  = 1026;
    localparam int WATCHDOG   = 20000;
    localparam int SWEEP_WAIT = 1200;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic       mode;
        logic       sof;
        logic [7:0] slot;
        rpdm_pkg::pixel_t rgba;
        logic [7:0] remap;
    } request_t;

    typedef struct {
        logic [7:0] code;
        logic       row_end;
    } mapped_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = rpdm_pkg::MODE_PALETTE;
    logic        s_start_of_image = 1'b0;
    logic [7:0]  s_entry_index = '0;
    logic [7:0]  s_red = '0;
    logic [7:0]  s_green = '0;
    logic [7:0]  s_blue = '0;
    logic [7:0]  s_alpha = '0;
    logic [7:0]  s_out_code = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_code;
    logic        m_row_end;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = rpdm_pkg::CFG_ROW_WIDTH;
    logic [10:0] cfg_data = '0;

    request_t pending_requests[$];
    request_t current;
    mapped_t  expected_codes[$];

    // Shadow state of the mapper.
    logic [31:0] palette_rgba[256];
    logic [7:0]  palette_remap[256];
    int          err_now[4][ROW_CELLS];
    int          err_below[4][ROW_CELLS];
    int          column;
    bit          reverse_row;
    int          width_reg = 1024;
    int          level_reg = 255;
    int          count_reg = 256;

    int errors = 0;
    int idle_pct = 36;
    int rx_hold = 0;
    int hold_len = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int stalled = 0;
    int pixels_done = 0;
    int palette_done = 0;
    int phases_done = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    rgba_palette_dither_mapper i_dut (.*);

    function automatic int saturate(longint v);
        longint hi = (longint'(1) <<< 23) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return int'(v);
    endfunction

    function automatic mapped_t map_pixel(request_t r);
        mapped_t res;
        int w, n, pos, col, best, d, diff;
        int bestdist;
        int adj[4];
        longint e, v;
        w = width_reg == 0 ? 1 : (width_reg > 1024 ? 1024 : width_reg);
        n = count_reg == 0 ? 1 : (count_reg > 256 ? 256 : count_reg);
        if (r.sof) begin
            foreach (err_now[c, k]) begin
                err_now[c][k] = 0;
                err_below[c][k] = 0;
            end
            column = 0;
            reverse_row = 1'b0;
        end
        pos = column >= w ? w - 1 : column;
        res.row_end = (pos == w - 1);
        col = reverse_row ? w - 1 - pos : pos;
        for (int c = 0; c < 4; c++) begin
            v = longint'(r.rgba[c]) + longint'(err_now[c][col + 1]) / 1024;
            if (v < 0) v = 0;
            if (v > level_reg) v = level_reg;
            adj[c] = int'(v);
        end
        best = 0;
        bestdist = 2000000000;
        for (int i = 0; i < n; i++) begin
            d = 0;
            for (int c = 0; c < 4; c++) begin
                diff = adj[c] - int'(palette_rgba[i][8*c +: 8]);
                d += diff * diff;
            end
            if (d < bestdist) begin
                bestdist = d;
                best = i;
            end
        end
        for (int c = 0; c < 4; c++) begin
            e = longint'(adj[c] - int'(palette_rgba[best][8*c +: 8])) * 1024;
            if (!reverse_row) begin
                err_now[c][col + 2] = saturate(err_now[c][col + 2] + (e * 7) / 16);
                err_below[c][col] = saturate(err_below[c][col] + (e * 3) / 16);
                err_below[c][col + 1] = saturate(err_below[c][col + 1] + (e * 5) / 16);
                err_below[c][col + 2] = saturate(err_below[c][col + 2] + e / 16);
            end else begin
                err_now[c][col] = saturate(err_now[c][col] + (e * 7) / 16);
                err_below[c][col + 2] = saturate(err_below[c][col + 2] + (e * 3) / 16);
                err_below[c][col + 1] = saturate(err_below[c][col + 1] + (e * 5) / 16);
                err_below[c][col] = saturate(err_below[c][col] + e / 16);
            end
        end
        res.code = palette_remap[best];
        if (res.row_end) begin
            err_now = err_below;
            foreach (err_below[c, k]) err_below[c][k] = 0;
            reverse_row = ~reverse_row;
            column = 0;
        end else begin
            column = (pos + 1) & 11'h7FF;
        end
        return res;
    endfunction

    // Sender: presents queued requests, with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (current.mode == rpdm_pkg::MODE_PIXEL) begin
                    expected_codes.push_back(map_pixel(current));
                    pixels_done++;
                end else begin
                    palette_rgba[current.slot] = current.rgba;
                    palette_remap[current.slot] = current.remap;
                    palette_done++;
                end
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    current = pending_requests.pop_front();
                    s_mode <= current.mode;
                    s_start_of_image <= current.sof;
                    s_entry_index <= current.slot;
                    s_red <= current.rgba[0];
                    s_green <= current.rgba[1];
                    s_blue <= current.rgba[2];
                    s_alpha <= current.rgba[3];
                    s_out_code <= current.remap;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected result code %h row_end %b", $realtime, m_code,
                             m_row_end);
                    errors++;
                end else begin
                    mapped_t exp_r;
                    exp_r = expected_codes.pop_front();
                    if (m_code !== exp_r.code) begin
                        $display("%0t: code expected %h actual %h", $realtime, exp_r.code,
                                 m_code);
                        errors++;
                    end
                    if (m_row_end !== exp_r.row_end) begin
                        $display("%0t: row_end expected %b actual %b", $realtime,
                                 exp_r.row_end, m_row_end);
                        errors++;
                    end
                end
            end
            if (hold_seq != hold_seen) begin
                hold_seen <= hold_seq;
                rx_hold <= hold_len;
                m_ready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(99) >= idle_pct;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stalled <= 0;
        else
            stalled <= stalled + 1;
        if (stalled >= WATCHDOG) begin
            $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int val);
        cfg_index <= idx;
        cfg_data <= 11'(val);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rpdm_pkg::CFG_ROW_WIDTH:     width_reg = val & 11'h7FF;
            rpdm_pkg::CFG_MAX_LEVEL:     level_reg = val & 8'hFF;
            rpdm_pkg::CFG_PALETTE_COUNT: count_reg = val & 9'h1FF;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (pending_requests.size() > 0 || s_valid || expected_codes.size() > 0)
            @(posedge aclk);
        repeat (SWEEP_WAIT) @(posedge aclk);
    endtask

    task automatic push_palette(int idx, logic [31:0] rgba, logic [7:0] remap);
        request_t r;
        r.mode = rpdm_pkg::MODE_PALETTE;
        r.sof = $urandom_range(1);
        r.slot = 8'(idx);
        r.rgba = rgba;
        r.remap = remap;
        pending_requests.push_back(r);
    endtask

    task automatic push_pixel(bit sof, logic [31:0] rgba);
        request_t r;
        r.mode = rpdm_pkg::MODE_PIXEL;
        r.sof = sof;
        r.slot = 8'($urandom);
        r.rgba = rgba;
        r.remap = 8'($urandom);
        pending_requests.push_back(r);
    endtask

    // One setting of the registers and a run of images under it.
    task automatic run_phase(int w, int lvl, int cnt, int npix, bit fresh, int hold);
        wait_idle();
        write_reg(rpdm_pkg::CFG_ROW_WIDTH, w);
        write_reg(rpdm_pkg::CFG_MAX_LEVEL, lvl);
        write_reg(rpdm_pkg::CFG_PALETTE_COUNT, cnt);
        hold_len = hold;
        hold_seq++;
        for (int k = 0; k < npix; k++) begin
            if ($urandom_range(99) < 4)
                push_palette($urandom_range(255), $urandom, 8'($urandom));
            push_pixel((k == 0 && fresh) || $urandom_range(99) < 2, $urandom);
        end
        phases_done++;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(CFG_UNUSED, 11'h7FF);
        write_reg(rpdm_pkg::CFG_ROW_WIDTH, 4);
        write_reg(rpdm_pkg::CFG_MAX_LEVEL, 255);
        write_reg(rpdm_pkg::CFG_PALETTE_COUNT, 256);
        push_palette(0, 32'h0000_0000, 8'h00);
        push_palette(1, 32'h0000_0000, 8'hFF);
        push_palette(255, 32'hFFFF_FFFF, 8'hA5);
        for (int i = 2; i < 255; i++) push_palette(i, $urandom, 8'($urandom));
        push_pixel(1'b1, 32'h0000_0000);
        push_pixel(1'b0, 32'hFFFF_FFFF);
        push_pixel(1'b0, 32'h8080_8080);
        push_pixel(1'b0, 32'hFF00_FF00);
        push_pixel(1'b0, 32'h00FF_00FF);
        push_pixel(1'b0, 32'h0000_0000);
        push_pixel(1'b1, 32'hFFFF_FFFF);
        push_pixel(1'b0, 32'h7F7F_7F7F);

        run_phase(4, 255, 256, 30, 1'b1, 0);
        run_phase(1, 255, 16, 20, 1'b1, 0);
        run_phase(7, 128, 1, 30, 1'b1, 3000);
        idle_pct = 0;
        run_phase(5, 255, 2, 60, 1'b1, 0);
        wait_idle();
        idle_pct = 36;
        run_phase(0, 1, 0, 15, 1'b1, 0);
        run_phase(8, 0, 511, 20, 1'b1, 0);
        run_phase(12, 200, 64, 6, 1'b1, 0);
        run_phase(3, 200, 64, 25, 1'b0, 0);
        run_phase(2047, 255, 256, 20, 1'b1, 0);
        run_phase(1024, 90, 8, 15, 1'b1, 0);
        run_phase(6, 255, 32, 100, 1'b1, 0);
        run_phase(3, 60, 256, 80, 1'b1, 0);
        wait_idle();

        $display("Mapped %0d pixels and loaded %0d palette entries over %0d settings,",
                 pixels_done, palette_done, phases_done);
        $display("covering widths, levels and palette sizes at their limits and a long stall.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> rgba_palette_dither_mapper.f
+incdir+rtl/core
rtl/core/rpdm_pkg.sv
rtl/core/rpdm_err_bank.sv
rtl/core/rpdm_nearest.sv
rtl/core/rgba_palette_dither_mapper.sv
bench/tb.sv
